>>> hdl/sqr_pkg.sv
// ----------------------------------------------------------------------------
// sqr_pkg
// Shared constants and types of the simplex quadrature rule generator.
// ----------------------------------------------------------------------------
package sqr_pkg;

	localparam int MAX_DIM   = 4;
	localparam int MAX_ORDER = 7;
	localparam int DIM_W     = 3;
	localparam int PART_W    = 2;
	localparam int LVL_W     = 2;

	localparam logic [1:0] CFG_DIMENSION = 2'd0;
	localparam logic [1:0] CFG_ORDER     = 2'd1;

	localparam logic [DIM_W-1:0] DIM_RESET   = 3'd2;
	localparam logic [2:0]       ORDER_RESET = 3'd1;

	typedef logic [MAX_DIM:0][PART_W-1:0] part_vec_t;

	typedef struct packed {
		logic              init;
		logic              adv;
		logic [LVL_W-1:0]  total;
		logic [DIM_W-1:0]  dim;
	} comp_ctrl_t;

endpackage

>>> hdl/simplex_quadrature_rule_generator.sv
// ----------------------------------------------------------------------------
// simplex_quadrature_rule_generator
// Emits every point of the Grundmann-Moeller simplex rule with exact weights.
// ----------------------------------------------------------------------------
// Usage:
//  - configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
//    is the dimension, index 1 the order; cfg_ready is always high and writes
//    are to be made while busy is low; the block itself does not enforce it
//  - a request is taken at a clock edge with start high and busy low; with
//    start_req low nothing is emitted and busy stays low
//  - with start_req high the block walks the levels of the rule; per level a
//    single 32x4 multiplier forms m! * cden^d and 2^(2s) * i! * (d+m-i)!, one
//    factor a cycle
//  - then one point is emitted per cycle; valid marks each point for one
//    cycle and last marks the final point
//  - the largest rule has 56 points (dimension 4, order 6 or 7); busy falls
//    in the cycle in which the last point is shown, so the next request can
//    be taken there
//  - the receiver cannot stall, points are never held back
//  - reset clears the sequencer and restores dimension 2 and order 1
// ----------------------------------------------------------------------------
module simplex_quadrature_rule_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [2:0]         cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic               start_req,
	output logic               valid,
	output logic [5:0]         point_index,
	output logic signed [30:0] weight_num,
	output logic [31:0]        weight_den,
	output logic [2:0]         coord0_num,
	output logic [2:0]         coord1_num,
	output logic [2:0]         coord2_num,
	output logic [2:0]         coord3_num,
	output logic [3:0]         coord_den,
	output logic               last
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LVL   = 3'd1;
	localparam logic [2:0] ST_NFACT = 3'd2;
	localparam logic [2:0] ST_NPOW  = 3'd3;
	localparam logic [2:0] ST_DFI   = 3'd4;
	localparam logic [2:0] ST_DFJ   = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0]  state_q;
	logic [2:0]  dim_cfg_q;
	logic [2:0]  ord_cfg_q;
	logic [2:0]  m_q;
	logic [1:0]  s_q;
	logic [1:0]  lvl_q;
	logic [3:0]  k_q;
	logic [31:0] acc_q;
	logic [29:0] wnum_q;
	logic [31:0] wden_q;
	logic [5:0]  pidx_q;

	logic               valid_q;
	logic [5:0]         point_index_q;
	logic signed [30:0] weight_num_q;
	logic [31:0]        weight_den_q;
	logic [3:0][2:0]    coord_q;
	logic [3:0]         coord_den_q;
	logic               last_q;

	logic [2:0]  d_w;
	logic [3:0]  cden_w;
	logic [3:0]  dmi_w;
	logic [3:0]  mul_b;
	logic [31:0] prod_w;
	logic [2:0]  dim_clamp;
	logic        accept;

	sqr_pkg::comp_ctrl_t comp_ctrl;
	sqr_pkg::part_vec_t  parts;
	logic                more;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;

	assign d_w    = {s_q, 1'b1};
	assign cden_w = 4'(d_w) + 4'(m_q) - {1'b0, lvl_q, 1'b0};
	assign dmi_w  = 4'(d_w) + 4'(m_q) - {2'b00, lvl_q};
	assign mul_b  = (state_q == ST_NPOW) ? cden_w : k_q;
	assign prod_w = acc_q * {28'd0, mul_b};

	always_comb begin
		if (dim_cfg_q == 3'd0) begin
			dim_clamp = 3'd1;
		end else if (dim_cfg_q > 3'(sqr_pkg::MAX_DIM)) begin
			dim_clamp = 3'(sqr_pkg::MAX_DIM);
		end else begin
			dim_clamp = dim_cfg_q;
		end
	end

	assign comp_ctrl.init  = (state_q == ST_DFJ) && (k_q > dmi_w);
	assign comp_ctrl.adv   = (state_q == ST_EMIT) && more;
	assign comp_ctrl.total = s_q - lvl_q;
	assign comp_ctrl.dim   = m_q;

	sqr_comp u_comp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (comp_ctrl),
		.parts  (parts),
		.more   (more)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_cfg_q <= sqr_pkg::DIM_RESET;
			ord_cfg_q <= sqr_pkg::ORDER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == sqr_pkg::CFG_DIMENSION) begin
				dim_cfg_q <= cfg_data;
			end else if (cfg_index == sqr_pkg::CFG_ORDER) begin
				ord_cfg_q <= cfg_data;
			end
		end
	end

	// sequencer and shared multiplier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			m_q     <= '0;
			s_q     <= '0;
			lvl_q   <= '0;
			k_q     <= '0;
			pidx_q  <= '0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && start_req) begin
						m_q     <= dim_clamp;
						s_q     <= ord_cfg_q[2:1];
						lvl_q   <= '0;
						pidx_q  <= '0;
						state_q <= ST_LVL;
					end
				end
				ST_LVL: begin
					k_q     <= 4'd2;
					state_q <= ST_NFACT;
				end
				ST_NFACT: begin
					if (k_q <= 4'(m_q)) begin
						k_q <= k_q + 4'd1;
					end else begin
						k_q     <= '0;
						state_q <= ST_NPOW;
					end
				end
				ST_NPOW: begin
					if (k_q < 4'(d_w)) begin
						k_q <= k_q + 4'd1;
					end else begin
						k_q     <= 4'd2;
						state_q <= ST_DFI;
					end
				end
				ST_DFI: begin
					if (k_q <= {2'b00, lvl_q}) begin
						k_q <= k_q + 4'd1;
					end else begin
						k_q     <= 4'd2;
						state_q <= ST_DFJ;
					end
				end
				ST_DFJ: begin
					if (k_q <= dmi_w) begin
						k_q <= k_q + 4'd1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					valid_q <= 1'b1;
					pidx_q  <= pidx_q + 6'd1;
					if (!more) begin
						if (lvl_q == s_q) begin
							state_q <= ST_IDLE;
						end else begin
							lvl_q   <= lvl_q + 2'd1;
							state_q <= ST_LVL;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// accumulator and point payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LVL: begin
				acc_q <= 32'd1;
			end
			ST_NFACT: begin
				if (k_q <= 4'(m_q)) begin
					acc_q <= prod_w;
				end
			end
			ST_NPOW: begin
				if (k_q < 4'(d_w)) begin
					acc_q <= prod_w;
				end else begin
					wnum_q <= acc_q[29:0];
					acc_q  <= 32'd1 << {s_q, 1'b0};
				end
			end
			ST_DFI: begin
				if (k_q <= {2'b00, lvl_q}) begin
					acc_q <= prod_w;
				end
			end
			ST_DFJ: begin
				if (k_q <= dmi_w) begin
					acc_q <= prod_w;
				end else begin
					wden_q <= acc_q;
				end
			end
			ST_EMIT: begin
				point_index_q <= pidx_q;
				weight_num_q  <= lvl_q[0] ? -$signed({1'b0, wnum_q}) : $signed({1'b0, wnum_q});
				weight_den_q  <= wden_q;
				for (int j = 0; j < sqr_pkg::MAX_DIM; j++) begin
					coord_q[j] <= (3'(j) < m_q) ? {parts[j+1], 1'b1} : 3'd0;
				end
				coord_den_q <= cden_w;
				last_q      <= (lvl_q == s_q) && !more;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign valid       = valid_q;
	assign point_index = point_index_q;
	assign weight_num  = weight_num_q;
	assign weight_den  = weight_den_q;
	assign coord0_num  = coord_q[0];
	assign coord1_num  = coord_q[1];
	assign coord2_num  = coord_q[2];
	assign coord3_num  = coord_q[3];
	assign coord_den   = coord_den_q;
	assign last        = last_q;

	// points only appear while a rule is being generated
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy))
		else $error("point emitted while idle");

	a_not_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last) |-> busy)
		else $error("generation ended without a final point");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && start_req) |=> busy)
		else $error("request with start_req high did not start generation");

	a_first_index: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && start_req) |=> (pidx_q == 6'd0))
		else $error("point numbering did not restart");

endmodule

>>> hdl/sqr_comp.sv
// ----------------------------------------------------------------------------
// sqr_comp
// Composition stepper: holds the current composition and advances it by one
// step in the next-composition order.
// ----------------------------------------------------------------------------
module sqr_comp (
	input  logic               clk,
	input  logic               arst_n,
	input  sqr_pkg::comp_ctrl_t ctrl,
	output sqr_pkg::part_vec_t parts,
	output logic               more
);

	sqr_pkg::part_vec_t parts_q;
	logic [2:0]         head_q;
	logic [1:0]         tail_q;
	logic               more_q;

	sqr_pkg::part_vec_t parts_nx;
	logic [2:0]         h_base;
	logic [2:0]         h_inc;
	logic [2:0]         h_w;
	logic [2:0]         hm1_w;
	logic [1:0]         t_w;
	logic [1:0]         last_nx;

	always_comb begin
		h_base = (tail_q > 2'd1) ? 3'd0 : head_q;
		h_inc  = h_base + 3'd1;
		h_w    = (h_inc > ctrl.dim) ? ctrl.dim : h_inc;
		hm1_w  = h_w - 3'd1;
		t_w    = '0;
		for (int j = 0; j <= sqr_pkg::MAX_DIM; j++) begin
			if (3'(j) == hm1_w) begin
				t_w = parts_q[j];
			end
		end
		for (int j = 0; j <= sqr_pkg::MAX_DIM; j++) begin
			parts_nx[j] = parts_q[j];
			if (3'(j) == hm1_w) begin
				parts_nx[j] = '0;
			end
			if (j == 0) begin
				parts_nx[j] = (t_w != 2'd0) ? t_w - 2'd1 : 2'd0;
			end
			if (3'(j) == h_w) begin
				parts_nx[j] = parts_nx[j] + 2'd1;
			end
		end
		last_nx = '0;
		for (int j = 0; j <= sqr_pkg::MAX_DIM; j++) begin
			if (3'(j) == ctrl.dim) begin
				last_nx = parts_nx[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parts_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			more_q  <= 1'b0;
		end else if (ctrl.init) begin
			parts_q <= {{(sqr_pkg::MAX_DIM * sqr_pkg::PART_W){1'b0}}, ctrl.total};
			head_q  <= '0;
			tail_q  <= ctrl.total;
			more_q  <= (ctrl.total != 2'd0);
		end else if (ctrl.adv) begin
			parts_q <= parts_nx;
			head_q  <= h_w;
			tail_q  <= t_w;
			more_q  <= (last_nx != ctrl.total);
		end
	end

	assign parts = parts_q;
	assign more  = more_q;

endmodule

>>> dv/simplex_quadrature_rule_generator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// simplex_quadrature_rule_generator_test
// Walks a short table of directed requests and register settings, then runs
// random phases of register settings and requests. Every emitted point is
// compared field by field with its table point or an exact integer model.
// ----------------------------------------------------------------------------
module simplex_quadrature_rule_generator_test;

	localparam int          ITEM_TARGET    = 500;
	localparam int          RESULT_CAP     = 56;
	localparam int          SETTLE_CYCLES  = 40;
	localparam int          DRAIN_CYCLES   = 200;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam logic [1:0]  CFG_UNMAPPED_LO = 2'd2;
	localparam logic [1:0]  CFG_UNMAPPED_HI = 2'd3;

	typedef struct packed {
		logic [5:0]       point_idx;
		logic [30:0]      wnum;
		logic [31:0]      wden;
		logic [3:0][2:0]  coord;
		logic [3:0]       cden;
		logic             last_pt;
	} rule_point_t;

	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		logic [1:0]   reg_idx;
		logic [2:0]   reg_data;
		logic         req;
		logic         has_value;
		rule_point_t  point;
	} stim_row_t;

	localparam rule_point_t NO_POINT = '0;
	localparam rule_point_t RESET_RULE_POINT =
		'{6'd0, 31'd6, 32'd6, {3'd0, 3'd0, 3'd1, 3'd1}, 4'd3, 1'b1};
	localparam rule_point_t DIM1_ORDER0_POINT =
		'{6'd0, 31'd2, 32'd2, {3'd0, 3'd0, 3'd0, 3'd1}, 4'd2, 1'b1};
	localparam rule_point_t DIM4_ORDER0_POINT =
		'{6'd0, 31'd120, 32'd120, {3'd1, 3'd1, 3'd1, 3'd1}, 4'd5, 1'b1};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [2:0]         cfg_data = '0;
	logic               start = 1'b0;
	logic               busy;
	logic               start_req = 1'b0;
	logic               valid;
	logic [5:0]         point_index;
	logic signed [30:0] weight_num;
	logic [31:0]        weight_den;
	logic [2:0]         coord0_num;
	logic [2:0]         coord1_num;
	logic [2:0]         coord2_num;
	logic [2:0]         coord3_num;
	logic [3:0]         coord_den;
	logic               last;

	// shadow registers and sequencer state of the rule model
	logic [2:0]   shadow_dim = sqr_pkg::DIM_RESET;
	logic [2:0]   shadow_order = sqr_pkg::ORDER_RESET;
	bit [1:0]     comp_parts [0:4];
	bit [2:0]     comp_head;
	bit [1:0]     comp_tail;
	bit           comp_more;
	bit [1:0]     rule_level;
	bit [5:0]     point_ctr;
	bit [29:0]    level_wnum;
	bit [31:0]    level_wden;

	rule_point_t  rule_points_due [$];
	stim_row_t    directed_rows [$];
	logic         row_fixed = 1'b0;
	rule_point_t  row_point = '0;
	int           mismatch_count = 0;
	int           requests_sent = 0;
	int           idle_cycles = 0;

	simplex_quadrature_rule_generator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start       (start),
		.busy        (busy),
		.start_req   (start_req),
		.valid       (valid),
		.point_index (point_index),
		.weight_num  (weight_num),
		.weight_den  (weight_den),
		.coord0_num  (coord0_num),
		.coord1_num  (coord1_num),
		.coord2_num  (coord2_num),
		.coord3_num  (coord3_num),
		.coord_den   (coord_den),
		.last        (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint unsigned fact(int unsigned n);
		longint unsigned v;
		v = 1;
		for (int unsigned k = 2; k <= n; k++)
			v *= k;
		return v;
	endfunction

	// no sender gaps and no register phases during one long stretch of requests
	function automatic bit in_steady_stretch();
		return (requests_sent >= 200) && (requests_sent < 300);
	endfunction

	// all points of one request at the current register setting
	task automatic build_rule();
		int unsigned m, s, d, cden, total, nparts, lv, j, emitted;
		longint unsigned wmag;
		rule_point_t pt;
		m = (shadow_dim < 1) ? 1 :
			((shadow_dim > sqr_pkg::MAX_DIM) ? sqr_pkg::MAX_DIM : shadow_dim);
		s = ((shadow_order > sqr_pkg::MAX_ORDER) ? sqr_pkg::MAX_ORDER : shadow_order) / 2;
		d = 2 * s + 1;
		nparts = m + 1;
		point_ctr = '0;
		emitted = 0;
		for (lv = 0; lv <= s; lv++) begin
			rule_level = 2'(lv);
			cden = d + m - 2 * lv;
			total = s - lv;
			wmag = fact(m);
			for (j = 0; j < d; j++)
				wmag *= cden;
			level_wnum = 30'(wmag);
			level_wden = 32'((64'd1 << (2 * s)) * fact(lv) * fact(d + m - lv));
			comp_more = 1'b0;
			comp_head = '0;
			comp_tail = '0;
			do begin
				if (!comp_more) begin
					comp_tail = 2'(total);
					comp_head = '0;
					comp_parts[0] = 2'(total);
					for (j = 1; j < nparts; j++)
						comp_parts[j] = '0;
				end else begin
					if (comp_tail > 1)
						comp_head = '0;
					comp_head++;
					if (comp_head >= nparts)
						comp_head = 3'(nparts - 1);
					comp_tail = comp_parts[comp_head - 1];
					comp_parts[comp_head - 1] = '0;
					comp_parts[0] = (comp_tail > 0) ? comp_tail - 2'd1 : 2'd0;
					comp_parts[comp_head]++;
				end
				comp_more = (comp_parts[nparts - 1] != total);
				if (emitted >= RESULT_CAP)
					return;
				pt.point_idx = point_ctr;
				pt.wnum = 31'(rule_level[0] ? 64'd0 - 64'(level_wnum) : 64'(level_wnum));
				pt.wden = level_wden;
				for (j = 0; j < 4; j++)
					pt.coord[j] = (j < m) ? 3'(2 * comp_parts[j + 1] + 1) : 3'd0;
				pt.cden = 4'(cden);
				pt.last_pt = (lv == s) && !comp_more;
				rule_points_due.push_back(pt);
				emitted++;
				point_ctr++;
			end while (comp_more);
		end
	endtask

	always @(posedge clk) begin : monitor
		rule_point_t seen, want;
		logic bad;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sqr_pkg::CFG_DIMENSION: shadow_dim = cfg_data;
					sqr_pkg::CFG_ORDER:     shadow_order = cfg_data;
					default: ;
				endcase
			end
			if (valid) begin
				seen = '{point_index, weight_num, weight_den,
					{coord3_num, coord2_num, coord1_num, coord0_num}, coord_den, last};
				if (rule_points_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected point: idx %0d wnum %0d wden %0d",
							point_index, weight_num, weight_den);
				end else begin
					want = rule_points_due.pop_front();
					bad = (seen.point_idx !== want.point_idx) || (seen.wnum !== want.wnum) ||
						(seen.wden !== want.wden) || (seen.coord[0] !== want.coord[0]) ||
						(seen.coord[1] !== want.coord[1]) || (seen.coord[2] !== want.coord[2]) ||
						(seen.coord[3] !== want.coord[3]) || (seen.cden !== want.cden) ||
						(seen.last_pt !== want.last_pt);
					if (bad) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("point mismatch, expected: idx %0d wnum %0d wden %0d",
								want.point_idx, $signed(want.wnum), want.wden,
								" c %0d %0d %0d %0d / %0d last %0d", want.coord[0],
								want.coord[1], want.coord[2], want.coord[3], want.cden,
								want.last_pt);
							$display("                  actual: idx %0d wnum %0d wden %0d",
								seen.point_idx, $signed(seen.wnum), seen.wden,
								" c %0d %0d %0d %0d / %0d last %0d", seen.coord[0],
								seen.coord[1], seen.coord[2], seen.coord[3], seen.cden,
								seen.last_pt);
						end
					end
				end
			end
			if (start && !busy && start_req) begin
				if (row_fixed)
					rule_points_due.push_back(row_point);
				else
					build_rule();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || valid || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_request(input logic req, input logic fixed_val, input rule_point_t pt);
		int gap;
		@(negedge clk);
		if (!in_steady_stretch() && $urandom_range(0, 99) < 10) begin
			gap = $urandom_range(1, 60);
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		start_req = req;
		row_fixed = fixed_val;
		row_point = pt;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (req)
			requests_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (rule_points_due.size() != 0 || busy)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [2:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		directed_rows.push_back('{ROW_REQ, 2'd0, 3'd0, 1'b1, 1'b1, RESET_RULE_POINT});
		directed_rows.push_back('{ROW_REQ, 2'd0, 3'd0, 1'b0, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_CFG, sqr_pkg::CFG_DIMENSION, 3'd1, 1'b0, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_CFG, sqr_pkg::CFG_ORDER, 3'd0, 1'b0, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_REQ, 2'd0, 3'd0, 1'b1, 1'b1, DIM1_ORDER0_POINT});
		directed_rows.push_back('{ROW_CFG, sqr_pkg::CFG_DIMENSION, 3'd4, 1'b0, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_REQ, 2'd0, 3'd0, 1'b1, 1'b1, DIM4_ORDER0_POINT});
		// largest rule, odd levels give negative weights
		directed_rows.push_back('{ROW_CFG, sqr_pkg::CFG_ORDER, 3'd7, 1'b0, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_REQ, 2'd0, 3'd0, 1'b1, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_CFG, sqr_pkg::CFG_ORDER, 3'd6, 1'b0, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_REQ, 2'd0, 3'd0, 1'b1, 1'b0, NO_POINT});
		// dimension out of range on both sides
		directed_rows.push_back('{ROW_CFG, sqr_pkg::CFG_DIMENSION, 3'd0, 1'b0, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_REQ, 2'd0, 3'd0, 1'b1, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_CFG, sqr_pkg::CFG_DIMENSION, 3'd7, 1'b0, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_CFG, sqr_pkg::CFG_ORDER, 3'd3, 1'b0, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_REQ, 2'd0, 3'd0, 1'b1, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_CFG, sqr_pkg::CFG_DIMENSION, 3'd3, 1'b0, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_CFG, sqr_pkg::CFG_ORDER, 3'd5, 1'b0, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_REQ, 2'd0, 3'd0, 1'b1, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_REQ, 2'd0, 3'd0, 1'b1, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_CFG, CFG_UNMAPPED_LO, 3'd7, 1'b0, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_CFG, CFG_UNMAPPED_HI, 3'd5, 1'b0, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_REQ, 2'd0, 3'd0, 1'b0, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_REQ, 2'd0, 3'd0, 1'b1, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_CFG, sqr_pkg::CFG_DIMENSION, 3'd2, 1'b0, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_CFG, sqr_pkg::CFG_ORDER, 3'd4, 1'b0, 1'b0, NO_POINT});
		directed_rows.push_back('{ROW_REQ, 2'd0, 3'd0, 1'b1, 1'b0, NO_POINT});

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_CFG) begin
				wait_idle();
				write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_data);
			end else begin
				send_request(directed_rows[r].req, directed_rows[r].has_value,
					directed_rows[r].point);
			end
		end

		while (requests_sent < ITEM_TARGET) begin
			if (!in_steady_stretch()) begin
				wait_idle();
				if ($urandom_range(0, 7) == 0)
					write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI,
						3'($urandom_range(0, 7)));
				write_reg(sqr_pkg::CFG_DIMENSION, ($urandom_range(0, 9) == 0)
					? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4)));
				write_reg(sqr_pkg::CFG_ORDER, 3'($urandom_range(0, 7)));
			end
			repeat ($urandom_range(2, 12))
				send_request($urandom_range(0, 9) != 0, 1'b0, NO_POINT);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && rule_points_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> sim.f
hdl/sqr_pkg.sv
hdl/sqr_comp.sv
hdl/simplex_quadrature_rule_generator.sv
dv/simplex_quadrature_rule_generator_test.sv
